// ===== hdl/stack_machine_alu_assert.svh =====
// ---------------------------------------------------------------------------
// Stack machine ALU assertion macros
// Concurrent checks, clocked on clock and held off during reset.
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_ALU_ASSERT_SVH
`define STACK_MACHINE_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every edge.
`define SMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by another.
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMA_ASSERT(lbl, prop, msg)
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/sma_pkg.sv =====
// ---------------------------------------------------------------------------
// Stack machine ALU package
// Sizes, operation and status codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none
package sma_pkg;
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int SP_BITS   = $clog2(DEPTH + 1);
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int OP_BITS   = 5;
   localparam int ST_BITS   = 3;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   localparam logic [OP_BITS-1:0] OP_ADD   = 5'd0;
   localparam logic [OP_BITS-1:0] OP_SUB   = 5'd1;
   localparam logic [OP_BITS-1:0] OP_MULU  = 5'd2;
   localparam logic [OP_BITS-1:0] OP_MULS  = 5'd3;
   localparam logic [OP_BITS-1:0] OP_DIVU  = 5'd4;
   localparam logic [OP_BITS-1:0] OP_DIVS  = 5'd5;
   localparam logic [OP_BITS-1:0] OP_AND   = 5'd6;
   localparam logic [OP_BITS-1:0] OP_OR    = 5'd7;
   localparam logic [OP_BITS-1:0] OP_XOR   = 5'd8;
   localparam logic [OP_BITS-1:0] OP_NOT   = 5'd9;
   localparam logic [OP_BITS-1:0] OP_LSL   = 5'd10;
   localparam logic [OP_BITS-1:0] OP_LSR   = 5'd11;
   localparam logic [OP_BITS-1:0] OP_ASR   = 5'd12;
   localparam logic [OP_BITS-1:0] OP_LT    = 5'd13;
   localparam logic [OP_BITS-1:0] OP_GT    = 5'd14;
   localparam logic [OP_BITS-1:0] OP_B     = 5'd15;
   localparam logic [OP_BITS-1:0] OP_A     = 5'd16;
   localparam logic [OP_BITS-1:0] OP_EQ    = 5'd17;
   localparam logic [OP_BITS-1:0] OP_CONST = 5'd18;
   localparam logic [OP_BITS-1:0] OP_DUP   = 5'd19;
   localparam logic [OP_BITS-1:0] OP_SWAP  = 5'd20;
   localparam logic [OP_BITS-1:0] OP_POP   = 5'd21;
   localparam logic [OP_BITS-1:0] OP_LIMIT = 5'd22;

   localparam logic [ST_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [ST_BITS-1:0] ST_UNDER   = 3'd1;
   localparam logic [ST_BITS-1:0] ST_OVER    = 3'd2;
   localparam logic [ST_BITS-1:0] ST_DIVZERO = 3'd3;
   localparam logic [ST_BITS-1:0] ST_INVALID = 3'd4;

   typedef struct packed {
      logic               load;
      logic               exec;
      logic               div_step;
      logic               div_fix;
      logic               commit;
      logic               report;
      logic [ST_BITS-1:0] status;
   } sma_cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [SP_BITS-1:0] sp;
      logic               top_zero;
      logic               slot_free;
   } sma_sts_type;

   // Entries popped by an operation
   function automatic logic [1:0] op_pops(input logic [OP_BITS-1:0] op);
      logic [1:0] n;
      n = 2'd2;
      if (op == OP_NOT || op == OP_DUP || op == OP_POP) n = 2'd1;
      if (op == OP_CONST || op >= OP_LIMIT) n = 2'd0;
      return n;
   endfunction

   // Entries pushed by an operation
   function automatic logic [1:0] op_pushes(input logic [OP_BITS-1:0] op);
      logic [1:0] n;
      n = 2'd1;
      if (op == OP_MULU || op == OP_MULS || op == OP_DIVU || op == OP_DIVS ||
          op == OP_DUP || op == OP_SWAP) n = 2'd2;
      if (op == OP_POP || op >= OP_LIMIT) n = 2'd0;
      return n;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/sma_ctrl.sv =====
// ---------------------------------------------------------------------------
// Stack machine ALU controller
// Checks each operation, sequences execute, divide, commit and report.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stack_machine_alu_assert.svh"
module sma_ctrl
   import sma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire sma_sts_type sts,
   output sma_cmd_type      cmd
);
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_DIV    = 6'b000100,
      S_DFIX   = 6'b001000,
      S_COMMIT = 6'b010000,
      S_REPORT = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [ST_BITS-1:0]    status_ff, status_in;
   logic [ST_BITS-1:0]    check;
   logic [1:0]            npop, npush;
   logic [SP_BITS:0]      depth_after;
   logic                  is_div;

   // Classify the pending operation
   always_comb begin
      npop        = op_pops(sts.op);
      npush       = op_pushes(sts.op);
      is_div      = (sts.op == OP_DIVU) || (sts.op == OP_DIVS);
      depth_after = {1'b0, sts.sp} - {{(SP_BITS-1){1'b0}}, npop}
                    + {{(SP_BITS-1){1'b0}}, npush};
      priority if (sts.op >= OP_LIMIT) begin
         check = ST_INVALID;
      end else if (sts.sp < {{(SP_BITS-2){1'b0}}, npop}) begin
         check = ST_UNDER;
      end else if (depth_after > (SP_BITS+1)'(DEPTH)) begin
         check = ST_OVER;
      end else if (is_div && sts.top_zero) begin
         check = ST_DIVZERO;
      end else begin
         check = ST_OK;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.status = status_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = check;
            cnt_in    = '0;
            if (check != ST_OK) begin
               state_in = S_REPORT;
            end else begin
               cmd.exec = 1'b1;
               state_in = is_div ? S_DIV : S_COMMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) state_in = S_DFIX;
         end
         S_DFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_REPORT;
         end
         S_REPORT: begin
            if (sts.slot_free) begin
               cmd.report = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   `SMA_ASSERT_NEXT(a_accept_exec, req_tvalid && req_tready, state_ff == S_EXEC, "accept must lead to execute")
   `SMA_ASSERT_NEXT(a_div_len, state_ff == S_DIV && cnt_ff == CNT_BITS'(WORD_BITS - 1), state_ff == S_DFIX, "divide must end after word bits")
   `SMA_ASSERT_NEXT(a_commit_report, cmd.commit, state_ff == S_REPORT && status_ff == ST_OK, "commit must report ok")
   `SMA_ASSERT(a_report_free, !cmd.report || sts.slot_free, "report into busy output")
endmodule
`default_nettype wire

// ===== hdl/sma_dpath.sv =====
// ---------------------------------------------------------------------------
// Stack machine ALU datapath
// Shift-register stack, ALU, multiplier, radix-2 divider and output register.
// ---------------------------------------------------------------------------
`default_nettype none
module sma_dpath
   import sma_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sma_cmd_type          cmd,
   input  wire logic [OP_BITS-1:0]   req_op,
   input  wire logic [WORD_BITS-1:0] req_imm,
   input  wire logic                 rsp_tready,
   output sma_sts_type               sts,
   output logic                      rsp_tvalid,
   output logic [WORD_BITS-1:0]      rsp_top,
   output logic [WORD_BITS-1:0]      rsp_next,
   output logic [SP_BITS-1:0]        rsp_depth,
   output logic [ST_BITS-1:0]        rsp_status
);
   logic [OP_BITS-1:0]   op_ff;
   logic [WORD_BITS-1:0] imm_ff;
   logic [WORD_BITS-1:0] stk_ff [DEPTH];
   logic [WORD_BITS-1:0] stk_in [DEPTH];
   logic [SP_BITS-1:0]   sp_ff;
   logic [WORD_BITS-1:0] first_ff, first_in, second_ff, second_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in, dvs_ff, dvs_in;
   logic                 qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic                 valid_ff;
   logic [WORD_BITS-1:0] top_ff, next_ff;
   logic [SP_BITS-1:0]   depth_ff;
   logic [ST_BITS-1:0]   status_ff;

   logic [WORD_BITS-1:0]   a, b;
   logic [4:0]             sh;
   logic                   sgn;
   logic [2*WORD_BITS+1:0] prod;
   logic [WORD_BITS:0]     rem_sh, trial;
   logic [1:0]             npop, npush;

   function automatic logic sgn_div(input logic [OP_BITS-1:0] op);
      return op == OP_DIVS;
   endfunction

   assign a    = stk_ff[0];
   assign b    = stk_ff[1];
   assign sh   = a[4:0];
   assign sgn  = (op_ff == OP_MULS);
   assign prod = $signed({sgn & b[WORD_BITS-1], b}) * $signed({sgn & a[WORD_BITS-1], a});

   assign npop  = op_pops(op_ff);
   assign npush = op_pushes(op_ff);

   // Execute one step of the operation
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      qneg_in   = qneg_ff;
      rneg_in   = rneg_ff;
      rem_sh    = {rem_ff[WORD_BITS-1:0], quo_ff[WORD_BITS-1]};
      trial     = rem_sh - {1'b0, dvs_ff};
      if (cmd.exec) begin
         unique case (op_ff)
            OP_ADD:  first_in = b + a;
            OP_SUB:  first_in = b - a;
            OP_MULU, OP_MULS: begin
               first_in  = prod[WORD_BITS-1:0];
               second_in = prod[2*WORD_BITS-1:WORD_BITS];
            end
            OP_DIVU, OP_DIVS: begin
               qneg_in = sgn_div(op_ff) & (a[WORD_BITS-1] ^ b[WORD_BITS-1]);
               rneg_in = sgn_div(op_ff) & b[WORD_BITS-1];
               dvs_in  = (sgn_div(op_ff) & a[WORD_BITS-1]) ? -a : a;
               quo_in  = (sgn_div(op_ff) & b[WORD_BITS-1]) ? -b : b;
               rem_in  = '0;
            end
            OP_AND:   first_in = a & b;
            OP_OR:    first_in = a | b;
            OP_XOR:   first_in = a ^ b;
            OP_NOT:   first_in = ~a;
            OP_LSL:   first_in = b << sh;
            OP_LSR:   first_in = b >> sh;
            OP_ASR:   first_in = $unsigned($signed(b) >>> sh);
            OP_LT:    first_in = WORD_BITS'($signed(a) < $signed(b));
            OP_GT:    first_in = WORD_BITS'($signed(a) > $signed(b));
            OP_B:     first_in = WORD_BITS'(a < b);
            OP_A:     first_in = WORD_BITS'(a > b);
            OP_EQ:    first_in = WORD_BITS'(a == b);
            OP_CONST: first_in = imm_ff;
            OP_DUP: begin
               first_in  = a;
               second_in = a;
            end
            OP_SWAP: begin
               first_in  = a;
               second_in = b;
            end
            default: ;
         endcase
      end
      // Restoring divide, one quotient bit a cycle
      if (cmd.div_step) begin
         if (!trial[WORD_BITS]) begin
            rem_in = trial;
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end
      end
      // Apply signs to quotient and remainder
      if (cmd.div_fix) begin
         first_in  = qneg_ff ? -quo_ff : quo_ff;
         second_in = rneg_ff ? -rem_ff[WORD_BITS-1:0] : rem_ff[WORD_BITS-1:0];
      end
   end

   // Pop operands and push results, one fixed place per entry
   always_comb begin
      int src;
      for (int i = 0; i < DEPTH; i++) begin
         src = i + int'(npop) - int'(npush);
         if (npush == 2'd2 && i == 0) begin
            stk_in[i] = second_ff;
         end else if (npush != 2'd0 && i == int'(npush) - 1) begin
            stk_in[i] = first_ff;
         end else if (src >= 0 && src < DEPTH) begin
            stk_in[i] = stk_ff[IDX_BITS'(src)];
         end else begin
            stk_in[i] = stk_ff[i];
         end
      end
   end

   // Hold operand, work and stack registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         imm_ff <= req_imm;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      qneg_ff   <= qneg_in;
      rneg_ff   <= rneg_in;
      if (cmd.commit) stk_ff <= stk_in;
      if (cmd.report) begin
         top_ff    <= (sp_ff >= SP_BITS'(1)) ? stk_ff[0] : '0;
         next_ff   <= (sp_ff >= SP_BITS'(2)) ? stk_ff[1] : '0;
         depth_ff  <= sp_ff;
         status_ff <= cmd.status;
      end
   end

   // Stack pointer and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) sp_ff <= sp_ff - SP_BITS'(npop) + SP_BITS'(npush);
         if (cmd.report) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.sp        = sp_ff;
      sts.top_zero  = (a == '0);
      sts.slot_free = !valid_ff || rsp_tready;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_top    = top_ff;
   assign rsp_next   = next_ff;
   assign rsp_depth  = depth_ff;
   assign rsp_status = status_ff;
endmodule
`default_nettype wire

// ===== hdl/stack_machine_alu.sv =====
// ---------------------------------------------------------------------------
// Stack machine ALU
// Zero-operand 32-bit stack machine executing one operation per transfer.
// ---------------------------------------------------------------------------
// Input channel req_*: one operation per transfer (opcode and constant).
// Result channel rsp_*: one transfer per operation with the new top, next,
// depth and a status code; failing operations leave the stack unchanged.
// Each accepted operation is checked in an execute state, then divides run
// the radix-2 divide loop and a sign fix, then the stack is committed and
// the result is loaded in a report state; rejected operations go from the
// check straight to report. Divides take the longest. One operation is in
// flight at a time, so the next input transfer is taken in the cycle after
// the result is loaded.
// The result sits in an output register; a new operation is accepted while
// it waits, and that operation holds before its own report until the
// receiver takes the earlier result.
// Reset empties the stack and drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none
module stack_machine_alu
   import sma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // op[4:0], imm[36:5], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // top[31:0], next[63:32], depth[68:64], status[71:69]
);
   sma_cmd_type          cmd;
   sma_sts_type          sts;
   logic [WORD_BITS-1:0] top, nxt;
   logic [SP_BITS-1:0]   depth;
   logic [ST_BITS-1:0]   status;

   sma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sma_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_op     (req_tdata[4:0]),
      .req_imm    (req_tdata[36:5]),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_top    (top),
      .rsp_next   (nxt),
      .rsp_depth  (depth),
      .rsp_status (status)
   );

   assign rsp_tdata = {status, depth, nxt, top};
endmodule
`default_nettype wire
